### hw/rtl/laplace_5pt_stencil_stream_top_assert.svh
// Assertion macros shared by the stencil RTL. They sample on clk and are
// disabled while the synchronous reset rst_n is low.
`ifndef LAPLACE_5PT_STENCIL_STREAM_TOP_ASSERT_SVH
`define LAPLACE_5PT_STENCIL_STREAM_TOP_ASSERT_SVH

// Consequence must hold in the same cycle as the condition.
`define LAP5_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Consequence must hold in the cycle after the condition.
`define LAP5_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### hw/rtl/lap5_pkg.sv
`default_nettype none

package lap5_pkg;

  localparam int MAX_SIDE_DEF     = 1024;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int GRID_SIDE_RST    = 2;
  localparam int GRID_SIDE_MIN    = 2;

  // Slots of the per-sample result list, in delivery order.
  localparam int RES_MID = 0;  // cell one row up, complete once the sample below arrives
  localparam int RES_BOT = 1;  // last-row cell to the left of the sample
  localparam int RES_END = 2;  // final cell of the frame
  localparam int RES_NUM = 3;

endpackage

`default_nettype wire

### hw/rtl/lap5_ram.sv
`default_nettype none

module lap5_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a read of the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/laplace_5pt_stencil_stream_top.sv
// Five-point Laplacian over a square grid streamed in row-major order.
// Input channel in_*: one signed sample per transaction. Output channel out_*:
// one result per transaction with its value, row and column; out_tlast marks
// the final cell of the grid. cfg_wr_en/cfg_wr_data set the grid side
// (clamped to 2..MAX_SIDE) and restart the frame; write it only while idle.
// Each sample is written to one of two row memories chosen by row parity and
// read back one row later, so a row's result is computed in the stencil stage
// once the sample directly below it is taken and then registered at the output
// (last-row results one sample late, the final cell with the final sample).
// Throughput: one sample per cycle through all rows but the last while the
// receiver accepts results; each last-row sample after the first yields two
// results (three for the final one), and the single output register then
// paces input at one result per cycle.
// Reset clears the frame position and both pipeline stages; the row memories
// are not cleared, since no entry is read before the current frame writes it.
// When out_tready is low the output register holds, the pending stage holds
// its remaining results, and in_tready drops once that stage cannot drain.
`default_nettype none

module laplace_5pt_stencil_stream_top #(
  parameter int MAX_SIDE     = lap5_pkg::MAX_SIDE_DEF,
  parameter int SAMPLE_WIDTH = lap5_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,

  input  wire logic                                     cfg_wr_en,
  input  wire logic [$clog2(MAX_SIDE):0]                cfg_wr_data,  // grid_side

  input  wire logic                                     in_tvalid,
  output logic                                          in_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        in_tdata,     // sample

  output logic                                          out_tvalid,
  input  wire logic                                     out_tready,
  // value, row, col (lowest bit first), zero padding above
  output logic [((SAMPLE_WIDTH+3+2*$clog2(MAX_SIDE)+7)/8)*8-1:0] out_tdata,
  output logic                                          out_tlast     // frame_end
);

  localparam int CW       = $clog2(MAX_SIDE);
  localparam int SIDEW    = CW + 1;
  localparam int VW       = SAMPLE_WIDTH + 3;
  localparam int OUT_BITS = ((VW + 2*CW + 7) / 8) * 8;

  localparam int RN = lap5_pkg::RES_NUM;

  // ---------------------------------------------------------------- input side
  logic signed [SAMPLE_WIDTH-1:0] s_in;
  logic                           in_acc;

  logic [SIDEW-1:0] side_r, side_nxt;
  logic [CW-1:0]    row_r, row_nxt, col_r, col_nxt;
  logic             par_r, par_nxt;
  logic signed [SAMPLE_WIDTH-1:0] row0_r, rec0_r, rec1_r;

  logic [SIDEW-1:0] side_m1;
  logic             col_last, row_last;
  logic [SIDEW-1:0] cfg_side;

  assign s_in     = in_tdata[SAMPLE_WIDTH-1:0];
  assign in_acc   = in_tvalid && in_tready;
  assign side_m1  = side_r - 1'b1;
  assign col_last = ({1'b0, col_r} == side_m1);
  assign row_last = ({1'b0, row_r} == side_m1);

  always_comb begin
    priority if (cfg_wr_data < SIDEW'(lap5_pkg::GRID_SIDE_MIN)) begin
      cfg_side = SIDEW'(lap5_pkg::GRID_SIDE_MIN);
    end else if (cfg_wr_data > SIDEW'(MAX_SIDE)) begin
      cfg_side = SIDEW'(MAX_SIDE);
    end else begin
      cfg_side = cfg_wr_data;
    end
  end

  always_comb begin
    side_nxt = side_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    par_nxt  = par_r;
    if (cfg_wr_en) begin
      side_nxt = cfg_side;
      row_nxt  = '0;
      col_nxt  = '0;
      par_nxt  = 1'b0;
    end else if (in_acc) begin
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt = '0;
          par_nxt = 1'b0;
        end else begin
          row_nxt = row_r + 1'b1;
          par_nxt = ~par_r;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDEW'(lap5_pkg::GRID_SIDE_RST);
      row_r  <= '0;
      col_r  <= '0;
      par_r  <= 1'b0;
    end else begin
      side_r <= side_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      par_r  <= par_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rec1_r <= rec0_r;
      rec0_r <= s_in;
      if (col_r == '0) begin
        row0_r <= s_in;
      end
    end
  end

  // ------------------------------------------------------------- row memories
  // The memory of the current row parity is read at the column being written
  // (two rows up) and the other one a column ahead (previous row, right side).
  logic [CW-1:0]         col_ahead;
  logic [SAMPLE_WIDTH-1:0] rd0, rd1;

  assign col_ahead = col_r + 1'b1;

  lap5_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_SIDE)
  ) u_ram0 (
    .clk   (clk),
    .we    (in_acc && !par_r),
    .waddr (col_r),
    .wdata (s_in),
    .re    (in_acc),
    .raddr (par_r ? col_ahead : col_r),
    .rdata (rd0)
  );

  lap5_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_SIDE)
  ) u_ram1 (
    .clk   (clk),
    .we    (in_acc && par_r),
    .waddr (col_r),
    .wdata (s_in),
    .re    (in_acc),
    .raddr (par_r ? col_r : col_ahead),
    .rdata (rd1)
  );

  // ---------------------------------------------------------- stencil stage
  logic                           s1_valid_r, s1_valid_nxt;
  logic [RN-1:0]                  s1_pend_r, s1_pend_nxt, pend_new;
  logic                           s1_par_r;
  logic [CW-1:0]                  s1_row_r, s1_col_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_s_r, s1_center_r, s1_left_r, s1_rec0_r, s1_rec1_r;
  logic                           s1_up_en_r, s1_left_en_r, s1_right_en_r, s1_left2_en_r;

  logic signed [SAMPLE_WIDTH-1:0] rd_cur, rd_prev;
  logic [RN-1:0]                  pick_oh, pend_left;
  logic                           out_load, emit, s1_done;

  assign rd_cur  = s1_par_r ? rd1 : rd0;
  assign rd_prev = s1_par_r ? rd0 : rd1;

  always_comb begin
    pend_new = '0;
    pend_new[lap5_pkg::RES_MID] = (row_r != '0);
    pend_new[lap5_pkg::RES_BOT] = row_last && (col_r != '0);
    pend_new[lap5_pkg::RES_END] = row_last && col_last;
  end

  assign out_load  = !out_tvalid || out_tready;
  assign pick_oh   = s1_pend_r & (~s1_pend_r + 1'b1);
  assign pend_left = s1_pend_r & ~pick_oh;
  assign emit      = s1_valid_r && (s1_pend_r != '0) && out_load;
  assign s1_done   = !s1_valid_r || (s1_pend_r == '0) || (emit && (pend_left == '0));
  assign in_tready = s1_done;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_pend_nxt  = s1_pend_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
      s1_pend_nxt  = pend_new;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
      s1_pend_nxt  = '0;
    end else if (emit) begin
      s1_pend_nxt  = pend_left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_pend_r  <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_pend_r  <= s1_pend_nxt;
    end
  end

  // The previous-row window slides with the stream: the right neighbour read
  // for the last sample is the center of this one, except at a row start.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_par_r      <= par_r;
      s1_row_r      <= row_r;
      s1_col_r      <= col_r;
      s1_s_r        <= s_in;
      s1_center_r   <= (col_r == '0) ? row0_r : rd_prev;
      s1_left_r     <= s1_center_r;
      s1_rec0_r     <= rec0_r;
      s1_rec1_r     <= rec1_r;
      s1_up_en_r    <= (row_r > CW'(1));
      s1_left_en_r  <= (col_r != '0);
      s1_left2_en_r <= (col_r > CW'(1));
      s1_right_en_r <= !col_last;
    end
  end

  logic signed [VW-1:0] x_s, x_center, x_left, x_rec0, x_rec1, x_cur, x_prev;
  logic signed [VW-1:0] val_mid, val_bot, val_end;

  assign x_s      = VW'(s1_s_r);
  assign x_center = VW'(s1_center_r);
  assign x_left   = VW'(s1_left_r);
  assign x_rec0   = VW'(s1_rec0_r);
  assign x_rec1   = VW'(s1_rec1_r);
  assign x_cur    = VW'(rd_cur);
  assign x_prev   = VW'(rd_prev);

  assign val_mid = (x_center <<< 2) - (s1_up_en_r ? x_cur : '0)
                 - (s1_left_en_r ? x_left : '0) - (s1_right_en_r ? x_prev : '0) - x_s;
  assign val_bot = (x_rec0 <<< 2) - x_left - (s1_left2_en_r ? x_rec1 : '0) - x_s;
  assign val_end = (x_s <<< 2) - x_center - x_rec0;

  // ---------------------------------------------------------- output register
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic signed [VW-1:0] out_value_r;
  logic [CW-1:0]        out_row_r, out_col_r;
  logic                 out_last_r;

  assign out_tvalid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      priority if (pick_oh[lap5_pkg::RES_MID]) begin
        out_value_r <= val_mid;
        out_row_r   <= s1_row_r - 1'b1;
        out_col_r   <= s1_col_r;
        out_last_r  <= 1'b0;
      end else if (pick_oh[lap5_pkg::RES_BOT]) begin
        out_value_r <= val_bot;
        out_row_r   <= s1_row_r;
        out_col_r   <= s1_col_r - 1'b1;
        out_last_r  <= 1'b0;
      end else begin
        out_value_r <= val_end;
        out_row_r   <= s1_row_r;
        out_col_r   <= s1_col_r;
        out_last_r  <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_BITS'({out_col_r, out_row_r, out_value_r});

  // ---------------------------------------------------------------- checks
`include "laplace_5pt_stencil_stream_top_assert.svh"

  `LAP5_ASSERT_NOW(a_hold_when_blocked, s1_valid_r && (s1_pend_r != '0) && !out_load, !in_tready, "stencil stage overwritten while results are pending")
  `LAP5_ASSERT_NOW(a_bot_col, s1_pend_r[lap5_pkg::RES_BOT], s1_col_r != '0, "left last-row result pending at a row start")
  `LAP5_ASSERT_NOW(a_last_cell, out_tvalid_r && out_last_r, ({1'b0, out_row_r} == side_m1) && ({1'b0, out_col_r} == side_m1), "frame end flagged away from the final cell")
  `LAP5_ASSERT_NEXT(a_stage_keeps, emit && (pend_left != '0), s1_valid_r, "stencil stage dropped a pending result")

endmodule

`default_nettype wire
